// File: hw/rtl/console_line_editor_unit_macros.svh
// Assertion helpers for the RTL of the console line editor.
// Every check is sampled on the rising clock edge and is held off while reset is low.
`ifndef CONSOLE_LINE_EDITOR_UNIT_MACROS_SVH
`define CONSOLE_LINE_EDITOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/cle_pkg.sv
package cle_pkg;

	// Result kinds.
	localparam logic [2:0] KIND_ECHO  = 3'd0;
	localparam logic [2:0] KIND_QUIET = 3'd1;
	localparam logic [2:0] KIND_FULL  = 3'd2;
	localparam logic [2:0] KIND_READ  = 3'd3;
	localparam logic [2:0] KIND_EMPTY = 3'd4;

	// Item functions.
	localparam logic FUNC_RX   = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// Characters with a meaning to the editor.
	localparam logic [7:0] CH_BS      = 8'h08;
	localparam logic [7:0] CH_LF      = 8'h0a;
	localparam logic [7:0] CH_CR      = 8'h0d;
	localparam logic [7:0] CH_ESC     = 8'h1b;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_UP      = 8'h41;
	localparam logic [7:0] CH_DOWN    = 8'h42;
	localparam logic [7:0] CH_RIGHT   = 8'h43;
	localparam logic [7:0] CH_LEFT    = 8'h44;
	localparam logic [7:0] CH_BRACKET = 8'h5b;
	localparam logic [7:0] CH_DEL     = 8'h7f;

	typedef enum logic [1:0] {
		ESC_NONE    = 2'd0,
		ESC_SEEN    = 2'd1,
		ESC_BRACKET = 2'd2
	} esc_state_t;

	// What one accepted item produces; a read takes its byte from the RAM later.
	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] beats;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       line_ready;
	} desc_t;

endpackage

// File: hw/rtl/console_line_editor_unit.sv
// Console line editor with a receive ring.
// Input channel (in_valid/in_ready, func, rx_byte): func 0 hands over a byte from the line,
// func 1 asks to pull the oldest stored byte. Each accepted beat yields one to three result
// beats on the output channel (out_valid/out_ready): kind, data_byte, line_ready,
// read_newline, with last marking the final beat of the item.
// Configuration channel (cfg_valid/cfg_ready, cfg_data) writes the echo enable bit; it is
// always ready and should only be written while the block is idle.
// Path: an accepted beat is decoded and the ring updated into the stage-one register, then
// the result register takes it and also absorbs the RAM read.
// Throughput: one item per cycle while each item gives one result and the receiver does
// not stall; an item that echoes bytes holds the result register until its last byte
// is taken, so line end holds it for two bytes and erase for three.
// The ring RAM has one write and one registered read port, used once per item at most.
// When the receiver stalls, the result register and the stage-one register fill and
// in_ready drops; nothing is lost. Reset empties the ring, clears the escape state,
// sets echo on and leaves the RAM contents undefined; no clearing pass is needed.
module console_line_editor_unit #(
	parameter int RING_DEPTH = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       func,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] kind,
	output logic [7:0] data_byte,
	output logic       line_ready,
	output logic       read_newline,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);

	localparam int PW = $clog2(RING_DEPTH);

	logic          ram_we, ram_re;
	logic [PW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;
	cle_pkg::desc_t desc_s1;
	logic          valid_s1, take_s1;

	assign cfg_ready = 1'b1;

	cle_ctrl #(
		.RING_DEPTH(RING_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.rx_byte  (rx_byte),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.desc_s1  (desc_s1),
		.valid_s1 (valid_s1),
		.take_s1  (take_s1)
	);

	cle_ram #(
		.WIDTH(8),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	cle_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.desc_s1     (desc_s1),
		.valid_s1    (valid_s1),
		.take_s1     (take_s1),
		.ram_rdata   (ram_rdata),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.data_byte   (data_byte),
		.line_ready  (line_ready),
		.read_newline(read_newline),
		.last        (last)
	);

endmodule

// File: hw/rtl/cle_ram.sv
module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/cle_ctrl.sv
module cle_ctrl #(
	parameter int RING_DEPTH = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [7:0]                    rx_byte,
	input  logic                          cfg_valid,
	input  logic                          cfg_data,
	output logic                          ram_we,
	output logic [$clog2(RING_DEPTH)-1:0] ram_waddr,
	output logic [7:0]                    ram_wdata,
	output logic                          ram_re,
	output logic [$clog2(RING_DEPTH)-1:0] ram_raddr,
	output cle_pkg::desc_t                desc_s1,
	output logic                          valid_s1,
	input  logic                          take_s1
);

	localparam int PW = $clog2(RING_DEPTH);
	localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);
	localparam logic [PW-1:0] PTR_ONE  = PW'(1);

	logic [PW-1:0] wp_q, rp_q, wp_d, rp_d, wp_next, wp_prev, rp_next;
	cle_pkg::esc_state_t esc_q, esc_d;
	logic echo_q;
	logic accept, full, empty;
	logic store, erase, queue;
	logic [7:0] ch;
	logic [1:0] n_echo;
	logic ready_flag;
	logic [7:0] e0, e1, e2;
	cle_pkg::desc_t desc_d;

	assign accept  = in_valid && in_ready;
	assign in_ready = !valid_s1 || take_s1;

	assign wp_next = (wp_q == PTR_LAST) ? '0 : wp_q + PTR_ONE;
	assign wp_prev = (wp_q == '0) ? PTR_LAST : wp_q - PTR_ONE;
	assign rp_next = (rp_q == PTR_LAST) ? '0 : rp_q + PTR_ONE;
	assign full    = (wp_next == rp_q);
	assign empty   = (wp_q == rp_q);

	always_comb begin
		wp_d       = wp_q;
		rp_d       = rp_q;
		esc_d      = esc_q;
		store      = 1'b0;
		erase      = 1'b0;
		queue      = 1'b0;
		ch         = rx_byte;
		n_echo     = 2'd0;
		ready_flag = 1'b0;
		e0         = '0;
		e1         = '0;
		e2         = '0;
		ram_re     = 1'b0;
		desc_d     = '0;
		desc_d.beats = 2'd1;

		if (func == cle_pkg::FUNC_READ) begin
			if (empty) begin
				desc_d.kind = cle_pkg::KIND_EMPTY;
			end else begin
				desc_d.kind = cle_pkg::KIND_READ;
				ram_re      = accept;
				rp_d        = rp_next;
			end
		end else if (full) begin
			desc_d.kind       = cle_pkg::KIND_FULL;
			desc_d.line_ready = 1'b1;
		end else begin
			case (rx_byte)
				cle_pkg::CH_CR, cle_pkg::CH_LF: begin
					store      = 1'b1;
					ch         = cle_pkg::CH_LF;
					e0         = cle_pkg::CH_LF;
					e1         = cle_pkg::CH_CR;
					n_echo     = 2'd2;
					ready_flag = 1'b1;
				end
				cle_pkg::CH_ESC: begin
					esc_d = cle_pkg::ESC_SEEN;
				end
				cle_pkg::CH_BRACKET: begin
					if (esc_q == cle_pkg::ESC_SEEN) begin
						esc_d = cle_pkg::ESC_BRACKET;
					end else begin
						queue = 1'b1;
					end
				end
				cle_pkg::CH_LEFT: begin
					if (esc_q == cle_pkg::ESC_BRACKET) begin
						erase = 1'b1;
					end else begin
						queue = 1'b1;
					end
				end
				cle_pkg::CH_UP, cle_pkg::CH_DOWN: begin
					if (esc_q == cle_pkg::ESC_BRACKET) begin
						esc_d = cle_pkg::ESC_NONE;
					end else begin
						queue = 1'b1;
					end
				end
				cle_pkg::CH_RIGHT: begin
					// Cursor right inside an escape sequence inserts a space.
					if (esc_q == cle_pkg::ESC_BRACKET) begin
						ch = cle_pkg::CH_SPACE;
					end
					queue = 1'b1;
				end
				cle_pkg::CH_BS, cle_pkg::CH_DEL: begin
					erase = 1'b1;
				end
				default: begin
					queue = 1'b1;
				end
			endcase

			if (erase) begin
				esc_d = cle_pkg::ESC_NONE;
				if (!empty) begin
					wp_d   = wp_prev;
					e0     = cle_pkg::CH_BS;
					e1     = cle_pkg::CH_SPACE;
					e2     = cle_pkg::CH_BS;
					n_echo = 2'd3;
				end
			end
			if (queue) begin
				esc_d  = cle_pkg::ESC_NONE;
				store  = 1'b1;
				e0     = ch;
				n_echo = 2'd1;
			end
			if (store) begin
				wp_d = wp_next;
			end

			desc_d.line_ready = ready_flag;
			if (!echo_q || n_echo == 2'd0) begin
				desc_d.kind = cle_pkg::KIND_QUIET;
			end else begin
				desc_d.kind  = cle_pkg::KIND_ECHO;
				desc_d.beats = n_echo;
				desc_d.b0    = e0;
				desc_d.b1    = e1;
				desc_d.b2    = e2;
			end
		end
	end

	assign ram_we    = accept && store;
	assign ram_waddr = wp_q;
	assign ram_wdata = ch;
	assign ram_raddr = rp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			esc_q    <= cle_pkg::ESC_NONE;
			echo_q   <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid) begin
				echo_q <= cfg_data;
			end
			if (accept) begin
				wp_q     <= wp_d;
				rp_q     <= rp_d;
				esc_q    <= esc_d;
				valid_s1 <= 1'b1;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc_d;
		end
	end

endmodule

// File: hw/rtl/cle_out.sv
`include "console_line_editor_unit_macros.svh"

module cle_out (
	input  logic           clk,
	input  logic           arst_n,
	input  cle_pkg::desc_t desc_s1,
	input  logic           valid_s1,
	output logic           take_s1,
	input  logic [7:0]     ram_rdata,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     kind,
	output logic [7:0]     data_byte,
	output logic           line_ready,
	output logic           read_newline,
	output logic           last
);

	logic       valid_q;
	logic [1:0] rem_q;
	logic [2:0] kind_q;
	logic [7:0] b0_q, b1_q, b2_q;
	logic       ready_q, nl_q;
	logic       load;
	logic [7:0] load_b0;
	logic       load_nl;

	assign last    = (rem_q == 2'd1);
	assign load    = !valid_q || (out_ready && last);
	assign take_s1 = valid_s1 && load;

	// The RAM read data lines up with the stage-one descriptor of a read item.
	always_comb begin
		load_b0 = desc_s1.b0;
		load_nl = 1'b0;
		if (desc_s1.kind == cle_pkg::KIND_READ) begin
			load_b0 = ram_rdata;
			load_nl = (ram_rdata == cle_pkg::CH_LF);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rem_q   <= 2'd1;
		end else if (load) begin
			valid_q <= valid_s1;
			if (valid_s1) begin
				rem_q <= desc_s1.beats;
			end
		end else if (out_ready) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && valid_s1) begin
			kind_q  <= desc_s1.kind;
			b0_q    <= load_b0;
			b1_q    <= desc_s1.b1;
			b2_q    <= desc_s1.b2;
			ready_q <= desc_s1.line_ready;
			nl_q    <= load_nl;
		end else if (!load && out_ready) begin
			b0_q <= b1_q;
			b1_q <= b2_q;
		end
	end

	assign out_valid    = valid_q;
	assign kind         = kind_q;
	assign data_byte    = b0_q;
	assign line_ready   = ready_q;
	assign read_newline = nl_q;

	`CLE_ASSERT_NOW(a_single_beat_kinds, out_valid && kind != cle_pkg::KIND_ECHO, last, "non-echo result must be a single beat")
	`CLE_ASSERT_NOW(a_full_flags, out_valid && kind == cle_pkg::KIND_FULL, line_ready && data_byte == 8'd0, "dropped byte must raise line ready with zero data")
	`CLE_ASSERT_NOW(a_newline_read, out_valid && read_newline, kind == cle_pkg::KIND_READ && data_byte == cle_pkg::CH_LF, "newline flag only on a read of LF")
	`CLE_ASSERT_NEXT(a_beat_advance, out_valid && out_ready && !last, out_valid && $past(line_ready) == line_ready && kind == cle_pkg::KIND_ECHO, "echo group must continue after a non-final beat")

endmodule
